@@ rtl/mivd_pkg.sv @@
package mivd_pkg;

  localparam int ID_SPACE  = 1024;
  localparam int FRAME_IDS = 16;

  localparam int ID_W   = $clog2(ID_SPACE);
  localparam int CNT_W  = 4;
  localparam int IDX_W  = (FRAME_IDS > 1) ? $clog2(FRAME_IDS) : 1;
  localparam int FILL_W = $clog2(FRAME_IDS + 1);
  localparam int MISS_W = 5;
  localparam int DATA_W = ((ID_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] COUNT_MAX       = 4'd15;
  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd10;
  localparam logic [CNT_W-1:0] STRIKE_RESET    = 4'd10;

  localparam logic OP_ID  = 1'b0;
  localparam logic OP_EOF = 1'b1;

  localparam logic REG_HIT_THRESHOLD = 1'b0;
  localparam logic REG_STRIKE_LIMIT  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ID_WR,
    ST_SCAN,
    ST_CHK,
    ST_EMIT,
    ST_FLUSH
  } mivd_state_t;

endpackage

@@ rtl/marker_id_validation_debounce_unit.sv @@
// Marker id debounce: send one word per detected id (tuser low) and one
// end-of-frame word (tuser high) per frame. An id word is a read and then a
// write of the id's 4-bit hit count in a 1024-entry count memory with
// separate read and write ports. At end of frame one shared compare walks the
// frame list of n ids once per distinct id (k of them) to find the next
// ascending id, then reads its count and clears it if it meets the threshold.
// A strike-limit clear adds a clearing pass through all 1024 entries of the
// count memory; the same pass runs after reset, with in_tready low and
// configuration writes still taken. Validated ids leave in ascending order,
// the final one of the frame with tlast set.
module marker_id_validation_debounce_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [mivd_pkg::DATA_W-1:0]  in_tdata,   // [9:0] marker_id
  input  logic                         in_tuser,   // [0] opcode
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [mivd_pkg::DATA_W-1:0]  out_tdata,  // [9:0] validated_id
  output logic                         out_tlast,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [mivd_pkg::CNT_W-1:0]   cfg_data
);

  mivd_pkg::mivd_state_t state_r, state_nxt;

  logic [mivd_pkg::CNT_W-1:0]  cnt_mem [mivd_pkg::ID_SPACE];
  logic [mivd_pkg::CNT_W-1:0]  mem_q_r;
  logic                        mem_we;
  logic [mivd_pkg::ID_W-1:0]   mem_wa, mem_ra;
  logic [mivd_pkg::CNT_W-1:0]  mem_wd;

  logic [mivd_pkg::ID_W-1:0]   list_r [mivd_pkg::FRAME_IDS];
  logic                        list_we;

  logic [mivd_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [mivd_pkg::MISS_W-1:0] miss_r, miss_nxt, miss_inc;
  logic [mivd_pkg::CNT_W-1:0]  thr_r, strike_r;
  logic [mivd_pkg::ID_W-1:0]   clr_idx_r, clr_idx_nxt;
  logic                        walk_pend_r, walk_pend_nxt;
  logic [mivd_pkg::ID_W-1:0]   id_r, id_nxt;

  logic [mivd_pkg::IDX_W-1:0]  scan_r, scan_nxt;
  logic                        found_r, found_nxt;
  logic [mivd_pkg::ID_W-1:0]   best_r, best_nxt;
  logic                        have_prev_r, have_prev_nxt;
  logic [mivd_pkg::ID_W-1:0]   prev_r, prev_nxt;
  logic                        hit_r, hit_nxt;

  logic                        pend_v_r, pend_v_nxt;
  logic [mivd_pkg::ID_W-1:0]   pend_id_r, pend_id_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [mivd_pkg::ID_W-1:0]   out_id_r, out_id_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        accept, can_push, walk_go;
  logic [mivd_pkg::ID_W-1:0]   scan_v, best_c;
  logic                        cand, take, found_c, scan_last;

  assign in_tready  = (state_r == mivd_pkg::ST_IDLE);
  assign accept     = in_tvalid & in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mivd_pkg::DATA_W - mivd_pkg::ID_W){1'b0}}, out_id_r};
  assign out_tlast  = out_last_r;
  assign can_push   = !out_valid_r || out_tready;
  assign miss_inc   = miss_r + mivd_pkg::MISS_W'(1);

  assign scan_v    = list_r[scan_r];
  assign cand      = !have_prev_r || (scan_v > prev_r);
  assign take      = cand && (!found_r || (scan_v < best_r));
  assign best_c    = take ? scan_v : best_r;
  assign found_c   = found_r || take;
  assign scan_last = ((mivd_pkg::FILL_W'(scan_r) + mivd_pkg::FILL_W'(1)) == fill_r);

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    miss_nxt      = miss_r;
    clr_idx_nxt   = clr_idx_r;
    walk_pend_nxt = walk_pend_r;
    id_nxt        = id_r;
    scan_nxt      = scan_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    have_prev_nxt = have_prev_r;
    prev_nxt      = prev_r;
    hit_nxt       = hit_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_id_nxt    = out_id_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_wa        = clr_idx_r;
    mem_wd        = '0;
    mem_ra        = in_tdata[mivd_pkg::ID_W-1:0];
    list_we       = 1'b0;
    walk_go       = 1'b0;

    case (state_r)
      mivd_pkg::ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + mivd_pkg::ID_W'(1);
        if (clr_idx_r == {mivd_pkg::ID_W{1'b1}}) begin
          if (walk_pend_r) begin
            walk_go = 1'b1;
          end else begin
            state_nxt = mivd_pkg::ST_IDLE;
          end
          walk_pend_nxt = 1'b0;
        end
      end
      mivd_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_tuser == mivd_pkg::OP_EOF) begin
            miss_nxt = (fill_r != '0) ? mivd_pkg::MISS_W'(1) : miss_inc;
            if (miss_nxt > mivd_pkg::MISS_W'(strike_r)) begin
              miss_nxt      = '0;
              clr_idx_nxt   = '0;
              walk_pend_nxt = 1'b1;
              state_nxt     = mivd_pkg::ST_CLEAR;
            end else begin
              walk_go = 1'b1;
            end
          end else if (fill_r < mivd_pkg::FILL_W'(mivd_pkg::FRAME_IDS)) begin
            list_we   = 1'b1;
            fill_nxt  = fill_r + mivd_pkg::FILL_W'(1);
            id_nxt    = in_tdata[mivd_pkg::ID_W-1:0];
            state_nxt = mivd_pkg::ST_ID_WR;
          end
        end
      end
      mivd_pkg::ST_ID_WR: begin
        mem_wa    = id_r;
        mem_wd    = mem_q_r + mivd_pkg::CNT_W'(1);
        mem_we    = (mem_q_r < mivd_pkg::COUNT_MAX);
        state_nxt = mivd_pkg::ST_IDLE;
      end
      mivd_pkg::ST_SCAN: begin
        if (!scan_last) begin
          scan_nxt  = scan_r + mivd_pkg::IDX_W'(1);
          found_nxt = found_c;
          best_nxt  = best_c;
        end else if (found_c) begin
          best_nxt      = best_c;
          prev_nxt      = best_c;
          have_prev_nxt = 1'b1;
          mem_ra        = best_c;
          state_nxt     = mivd_pkg::ST_CHK;
        end else begin
          state_nxt = mivd_pkg::ST_FLUSH;
        end
      end
      mivd_pkg::ST_CHK: begin
        hit_nxt   = (mem_q_r >= thr_r);
        mem_wa    = best_r;
        mem_we    = hit_nxt;
        state_nxt = mivd_pkg::ST_EMIT;
      end
      mivd_pkg::ST_EMIT: begin
        if (!hit_r) begin
          scan_nxt  = '0;
          found_nxt = 1'b0;
          state_nxt = mivd_pkg::ST_SCAN;
        end else if (!pend_v_r || can_push) begin
          if (pend_v_r) begin
            out_valid_nxt = 1'b1;
            out_id_nxt    = pend_id_r;
            out_last_nxt  = 1'b0;
          end
          pend_v_nxt  = 1'b1;
          pend_id_nxt = best_r;
          scan_nxt    = '0;
          found_nxt   = 1'b0;
          state_nxt   = mivd_pkg::ST_SCAN;
        end
      end
      mivd_pkg::ST_FLUSH: begin
        if (!pend_v_r) begin
          fill_nxt  = '0;
          state_nxt = mivd_pkg::ST_IDLE;
        end else if (can_push) begin
          out_valid_nxt = 1'b1;
          out_id_nxt    = pend_id_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          fill_nxt      = '0;
          state_nxt     = mivd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mivd_pkg::ST_IDLE;
      end
    endcase

    if (walk_go) begin
      scan_nxt      = '0;
      found_nxt     = 1'b0;
      have_prev_nxt = 1'b0;
      state_nxt     = (fill_r == '0) ? mivd_pkg::ST_FLUSH : mivd_pkg::ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mivd_pkg::ST_CLEAR;
      fill_r      <= '0;
      miss_r      <= '0;
      clr_idx_r   <= '0;
      walk_pend_r <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= mivd_pkg::THRESHOLD_RESET;
      strike_r    <= mivd_pkg::STRIKE_RESET;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      miss_r      <= miss_nxt;
      clr_idx_r   <= clr_idx_nxt;
      walk_pend_r <= walk_pend_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          mivd_pkg::REG_HIT_THRESHOLD: thr_r    <= cfg_data;
          mivd_pkg::REG_STRIKE_LIMIT:  strike_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    id_r        <= id_nxt;
    scan_r      <= scan_nxt;
    found_r     <= found_nxt;
    best_r      <= best_nxt;
    have_prev_r <= have_prev_nxt;
    prev_r      <= prev_nxt;
    hit_r       <= hit_nxt;
    pend_id_r   <= pend_id_nxt;
    out_id_r    <= out_id_nxt;
    out_last_r  <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_wa] <= mem_wd;
    end
    mem_q_r <= cnt_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (list_we) begin
      list_r[fill_r[mivd_pkg::IDX_W-1:0]] <= in_tdata[mivd_pkg::ID_W-1:0];
    end
  end

endmodule

@@ rtl/mivd_checker.sv @@
module mivd_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [mivd_pkg::DATA_W-1:0] out_tdata,
  input logic                        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled output word changed");

  a_busy_after_eof: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == mivd_pkg::OP_EOF) |=> !in_tready)
    else $error("input taken right after an end-of-frame word");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[mivd_pkg::DATA_W-1:mivd_pkg::ID_W] == '0)
    else $error("output padding not zero");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("busy or output state wrong after reset");

endmodule

bind marker_id_validation_debounce_unit mivd_checker u_mivd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

@@ test/mivd_checker.sv @@
`timescale 1ns / 1ps

module mivd_monitor (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [mivd_pkg::DATA_W-1:0] in_tdata,
  input  logic                        in_tuser,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [mivd_pkg::DATA_W-1:0] out_tdata,
  input  logic                        out_tlast,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [mivd_pkg::CNT_W-1:0]  cfg_data,
  output int                          fail_count,
  output int                          pending
);

  typedef struct packed {
    logic [mivd_pkg::ID_W-1:0] id;
    logic                      last;
  } validated_t;

  logic [mivd_pkg::CNT_W-1:0]  hit_tally [mivd_pkg::ID_SPACE];
  logic [mivd_pkg::MISS_W-1:0] miss_run;
  logic [mivd_pkg::ID_W-1:0]   frame_ids [$];
  logic [mivd_pkg::CNT_W-1:0]  threshold;
  logic [mivd_pkg::CNT_W-1:0]  strikes;
  validated_t                  validated_q [$];
  int                          errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  task automatic count_hit(input logic [mivd_pkg::ID_W-1:0] id);
    if (frame_ids.size() < mivd_pkg::FRAME_IDS) begin
      frame_ids = {frame_ids, id};
      if (hit_tally[id] < mivd_pkg::COUNT_MAX) hit_tally[id] = hit_tally[id] + 1'b1;
    end
  endtask

  task automatic close_frame();
    logic [mivd_pkg::ID_SPACE-1:0] listed;
    logic [mivd_pkg::ID_W-1:0]     passed [$];
    validated_t                    word;
    listed = '0;
    foreach (frame_ids[i]) listed[frame_ids[i]] = 1'b1;
    if (frame_ids.size() > 0) miss_run = mivd_pkg::MISS_W'(1);
    else miss_run = miss_run + 1'b1;
    if (miss_run > {1'b0, strikes}) begin
      foreach (hit_tally[i]) hit_tally[i] = '0;
      miss_run = '0;
    end
    // ascending walk over the distinct ids of this frame
    for (int v = 0; v < mivd_pkg::ID_SPACE; v++) begin
      if (listed[v] && hit_tally[v] >= threshold) begin
        hit_tally[v] = '0;
        passed = {passed, mivd_pkg::ID_W'(v)};
      end
    end
    foreach (passed[i]) begin
      word.id   = passed[i];
      word.last = (i == passed.size() - 1);
      validated_q = {validated_q, word};
    end
    frame_ids.delete();
  endtask

  task automatic check_word();
    validated_t want;
    if (validated_q.size() == 0) begin
      $error("validated_id: expected none, got %0d", out_tdata);
      errors++;
    end else begin
      want = validated_q.pop_front();
      if (out_tdata !== mivd_pkg::DATA_W'(want.id)) begin
        $error("validated_id: expected %0d, got %0d", want.id, out_tdata);
        errors++;
      end
      if (out_tlast !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, out_tlast);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (hit_tally[i]) hit_tally[i] = '0;
      miss_run  = '0;
      frame_ids.delete();
      validated_q.delete();
      threshold = mivd_pkg::THRESHOLD_RESET;
      strikes   = mivd_pkg::STRIKE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mivd_pkg::REG_HIT_THRESHOLD) threshold = cfg_data;
        else strikes = cfg_data;
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == mivd_pkg::OP_EOF) close_frame();
        else count_hit(in_tdata[mivd_pkg::ID_W-1:0]);
      end
      if (out_tvalid && out_tready) check_word();
    end
    pending    <= validated_q.size();
    fail_count <= errors;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int SETTLE      = 1400;
  localparam int QUIET_LIMIT = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_WORDS = 20;

  logic                        clk        = 1'b0;
  logic                        rst_n      = 1'b0;
  logic                        in_tvalid  = 1'b0;
  logic [mivd_pkg::DATA_W-1:0] in_tdata   = '0;
  logic                        in_tuser   = 1'b0;
  logic                        out_tready = 1'b0;
  logic                        cfg_valid  = 1'b0;
  logic                        cfg_index  = 1'b0;
  logic [mivd_pkg::CNT_W-1:0]  cfg_data   = '0;
  wire                         in_tready;
  wire                         out_tvalid;
  wire  [mivd_pkg::DATA_W-1:0] out_tdata;
  wire                         out_tlast;
  wire                         cfg_ready;

  int                        fail_count;
  int                        pending;
  int                        in_idle_pct  = 34;
  int                        out_idle_pct = 46;
  bit                        hold_req     = 1'b0;
  int                        hold_left    = 0;
  int                        quiet_cycles = 0;
  int                        word_total   = 0;
  int                        thr_plan [6]    = '{2, 1, 15, 0, 3, 10};
  int                        strike_plan [6] = '{1, 3, 15, 0, 2, 10};
  logic [mivd_pkg::ID_W-1:0] pool [4];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  marker_id_validation_debounce_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mivd_monitor u_monitor (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_word(input logic op, input logic [mivd_pkg::ID_W-1:0] id);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= mivd_pkg::DATA_W'(id);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    word_total++;
  endtask

  task automatic set_regs(input logic [mivd_pkg::CNT_W-1:0] thr,
                          input logic [mivd_pkg::CNT_W-1:0] strike);
    cfg_valid <= 1'b1;
    cfg_index <= mivd_pkg::REG_HIT_THRESHOLD;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= mivd_pkg::REG_STRIKE_LIMIT;
    cfg_data  <= strike;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold the sender until every validated id is out, then let the walk settle
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_frame();
    int                        kind;
    int                        n;
    logic [mivd_pkg::ID_W-1:0] id;
    kind = $urandom_range(0, 99);
    if (kind < 20) n = 0;
    else if (kind < 30) n = $urandom_range(mivd_pkg::FRAME_IDS + 1, mivd_pkg::FRAME_IDS + 3);
    else n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 80) id = pool[$urandom_range(0, 3)];
      else id = mivd_pkg::ID_W'($urandom_range(0, mivd_pkg::ID_SPACE - 1));
      send_word(mivd_pkg::OP_ID, id);
    end
    send_word(mivd_pkg::OP_EOF, mivd_pkg::ID_W'($urandom_range(0, mivd_pkg::ID_SPACE - 1)));
  endtask

  initial begin
    int goal;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_regs(4'd1, 4'd15);
    send_word(mivd_pkg::OP_ID, 10'd1023);
    send_word(mivd_pkg::OP_ID, 10'd0);
    send_word(mivd_pkg::OP_ID, 10'd1023);
    send_word(mivd_pkg::OP_ID, 10'd512);
    send_word(mivd_pkg::OP_EOF, 10'd1023);
    send_word(mivd_pkg::OP_EOF, 10'd0);
    for (int i = 0; i < mivd_pkg::FRAME_IDS; i++) send_word(mivd_pkg::OP_ID, mivd_pkg::ID_W'(i));
    send_word(mivd_pkg::OP_ID, 10'd700);
    send_word(mivd_pkg::OP_EOF, 10'd0);
    drain();

    for (int p = 0; p < 6; p++) begin
      in_idle_pct  = (p < 2) ? 34 : (p < 4) ? 46 : 0;
      out_idle_pct = (p < 2) ? 46 : (p < 4) ? 34 : 0;
      set_regs(mivd_pkg::CNT_W'(thr_plan[p]), mivd_pkg::CNT_W'(strike_plan[p]));
      foreach (pool[j]) pool[j] = mivd_pkg::ID_W'($urandom_range(0, mivd_pkg::ID_SPACE - 1));
      if (p == 1) hold_req = 1'b1;
      goal = word_total + PHASE_WORDS;
      while (word_total < goal) send_frame();
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
